// File: rtl/core/assert_macros.svh
// Assertion macros shared by the sequencer RTL.
// Needs no other file; included where a module checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define TGRS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while in reset.
`define TGRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/core/tgrs_pkg.sv
// Shared widths, codes, reset values and types for the throttle/gear sequencer.
// No dependencies.
package tgrs_pkg;

  localparam int WID_W  = 12;   // pulse width in us
  localparam int PAR_W  = 16;   // timer period parameters
  localparam int TICK_W = 16;
  localparam int STEP_W = 8;
  localparam int HOLD_W = 8;
  localparam int TGT_W  = 36;
  localparam int RAMP_W = 32;
  localparam int PROD_W = WID_W + PAR_W;
  localparam int ADDR_W = 6;
  localparam int DATA_W = 64;

  localparam int unsigned TIMER_TICKS_DEF     = 5000;
  localparam int unsigned USEC_PER_PERIOD_DEF = 20000;

  localparam logic [1:0] OP_FORWARD = 2'd0;
  localparam logic [1:0] OP_REVERSE = 2'd1;
  localparam logic [1:0] OP_STOP    = 2'd2;
  localparam logic [1:0] OP_STEER   = 2'd3;

  localparam logic [1:0] SPEED_CREEP     = 2'd0;
  localparam logic [1:0] SPEED_CRUISE    = 2'd1;
  localparam logic [1:0] SPEED_LUDICROUS = 2'd2;
  localparam logic [1:0] SPEED_STOP      = 2'd3;

  localparam logic [1:0] GEAR_IDLE    = 2'd0;
  localparam logic [1:0] GEAR_DRIVE   = 2'd1;
  localparam logic [1:0] GEAR_PREREV  = 2'd2;
  localparam logic [1:0] GEAR_REVERSE = 2'd3;

  localparam logic [2:0] REG_NEUTRAL_WIDTH = 3'd0;
  localparam logic [2:0] REG_FWD_TARGETS   = 3'd1;
  localparam logic [2:0] REG_REV_TARGETS   = 3'd2;
  localparam logic [2:0] REG_RAMP_STEPS    = 3'd3;
  localparam logic [2:0] REG_PREREV_WIDTH  = 3'd4;
  localparam logic [2:0] REG_PREREV_HOLD   = 3'd5;
  localparam logic [2:0] REG_STEER_RIGHT   = 3'd6;
  localparam logic [2:0] REG_STEER_LEFT    = 3'd7;

  localparam logic [WID_W-1:0]  RST_NEUTRAL_WIDTH = 12'd1500;
  localparam logic [TGT_W-1:0]  RST_FWD_TARGETS   = 36'd28527822360;
  localparam logic [TGT_W-1:0]  RST_REV_TARGETS   = 36'd21816116640;
  localparam logic [RAMP_W-1:0] RST_RAMP_STEPS    = 32'd168430090;
  localparam logic [WID_W-1:0]  RST_PREREV_WIDTH  = 12'd1400;
  localparam logic [HOLD_W-1:0] RST_PREREV_HOLD   = 8'd10;
  localparam logic [WID_W-1:0]  RST_STEER_RIGHT   = 12'd1000;
  localparam logic [WID_W-1:0]  RST_STEER_LEFT    = 12'd2000;
  localparam logic [WID_W-1:0]  RST_STEER_WIDTH   = 12'd1500;

  typedef struct packed {
    logic [WID_W-1:0]  neutral_width;
    logic [TGT_W-1:0]  fwd_targets;
    logic [TGT_W-1:0]  rev_targets;
    logic [RAMP_W-1:0] ramp_steps;
    logic [WID_W-1:0]  prerev_width;
    logic [HOLD_W-1:0] prerev_hold;
    logic [WID_W-1:0]  steer_right;
    logic [WID_W-1:0]  steer_left;
  } cfg_t;

  // One word between the state update and the tick conversion.
  typedef struct packed {
    logic [WID_W-1:0] thr_width;
    logic [WID_W-1:0] str_width;
    logic [1:0]       gear;
    logic             written;
  } item_t;

endpackage

// File: rtl/core/tgrs_cfg.sv
// APB register file for the sequencer settings.
// Depends on tgrs_pkg.
module tgrs_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic [tgrs_pkg::ADDR_W-1:0] paddr_i,
  input  logic [tgrs_pkg::DATA_W-1:0] pwdata_i,
  output logic [tgrs_pkg::DATA_W-1:0] prdata_o,
  output logic                        pready_o,
  output tgrs_pkg::cfg_t              cfg_o
);

  tgrs_pkg::cfg_t cfg_q;
  logic [2:0]     idx;
  logic           wr_en;

  assign idx      = paddr_i[tgrs_pkg::ADDR_W-1:3];
  assign wr_en    = psel_i && penable_i && pwrite_i;
  assign pready_o = 1'b1;
  assign cfg_o    = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.neutral_width <= tgrs_pkg::RST_NEUTRAL_WIDTH;
      cfg_q.fwd_targets   <= tgrs_pkg::RST_FWD_TARGETS;
      cfg_q.rev_targets   <= tgrs_pkg::RST_REV_TARGETS;
      cfg_q.ramp_steps    <= tgrs_pkg::RST_RAMP_STEPS;
      cfg_q.prerev_width  <= tgrs_pkg::RST_PREREV_WIDTH;
      cfg_q.prerev_hold   <= tgrs_pkg::RST_PREREV_HOLD;
      cfg_q.steer_right   <= tgrs_pkg::RST_STEER_RIGHT;
      cfg_q.steer_left    <= tgrs_pkg::RST_STEER_LEFT;
    end else if (wr_en) begin
      case (idx)
        tgrs_pkg::REG_NEUTRAL_WIDTH:
          cfg_q.neutral_width <= pwdata_i[tgrs_pkg::WID_W-1:0];
        tgrs_pkg::REG_FWD_TARGETS:   cfg_q.fwd_targets <= pwdata_i[tgrs_pkg::TGT_W-1:0];
        tgrs_pkg::REG_REV_TARGETS:   cfg_q.rev_targets <= pwdata_i[tgrs_pkg::TGT_W-1:0];
        tgrs_pkg::REG_RAMP_STEPS:    cfg_q.ramp_steps  <= pwdata_i[tgrs_pkg::RAMP_W-1:0];
        tgrs_pkg::REG_PREREV_WIDTH:
          cfg_q.prerev_width <= pwdata_i[tgrs_pkg::WID_W-1:0];
        tgrs_pkg::REG_PREREV_HOLD:   cfg_q.prerev_hold <= pwdata_i[tgrs_pkg::HOLD_W-1:0];
        tgrs_pkg::REG_STEER_RIGHT:   cfg_q.steer_right <= pwdata_i[tgrs_pkg::WID_W-1:0];
        default:                     cfg_q.steer_left  <= pwdata_i[tgrs_pkg::WID_W-1:0];
      endcase
    end
  end

  always_comb begin
    case (idx)
      tgrs_pkg::REG_NEUTRAL_WIDTH: prdata_o = tgrs_pkg::DATA_W'(cfg_q.neutral_width);
      tgrs_pkg::REG_FWD_TARGETS:   prdata_o = tgrs_pkg::DATA_W'(cfg_q.fwd_targets);
      tgrs_pkg::REG_REV_TARGETS:   prdata_o = tgrs_pkg::DATA_W'(cfg_q.rev_targets);
      tgrs_pkg::REG_RAMP_STEPS:    prdata_o = tgrs_pkg::DATA_W'(cfg_q.ramp_steps);
      tgrs_pkg::REG_PREREV_WIDTH:  prdata_o = tgrs_pkg::DATA_W'(cfg_q.prerev_width);
      tgrs_pkg::REG_PREREV_HOLD:   prdata_o = tgrs_pkg::DATA_W'(cfg_q.prerev_hold);
      tgrs_pkg::REG_STEER_RIGHT:   prdata_o = tgrs_pkg::DATA_W'(cfg_q.steer_right);
      default:                     prdata_o = tgrs_pkg::DATA_W'(cfg_q.steer_left);
    endcase
  end

endmodule

// File: rtl/core/tgrs_seq.sv
// Command state update: throttle ramp, gear sequence, hold counter, steering clamp.
// Depends on tgrs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tgrs_seq (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  tgrs_pkg::cfg_t             cfg_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 op_i,
  input  logic [1:0]                 spd_i,
  input  logic [tgrs_pkg::WID_W-1:0] sw_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output tgrs_pkg::item_t            out_item_o
);

  localparam int W = tgrs_pkg::WID_W;
  localparam int S = tgrs_pkg::STEP_W;

  function automatic logic [W-1:0] sub_sat(input logic [W-1:0] a, input logic [S-1:0] b);
    logic [W-1:0] bw;
    bw = W'(b);
    return (a > bw) ? a - bw : '0;
  endfunction

  function automatic logic [W-1:0] add_sat(input logic [W-1:0] a, input logic [S-1:0] b);
    logic [W:0] s;
    s = {1'b0, a} + (W + 1)'(b);
    return s[W] ? {W{1'b1}} : s[W-1:0];
  endfunction

  logic [W-1:0] thr_q, thr_d, str_q, str_d;
  logic [1:0]   gear_q, gear_d;
  logic [tgrs_pkg::HOLD_W-1:0] hold_q, hold_d;
  logic         wr_d;
  logic         valid_q;
  tgrs_pkg::item_t item_q;
  logic         accept;

  logic [W-1:0] stop_thr;
  logic [1:0]   stop_gear;
  logic [W-1:0] fwd_tgt, rev_tgt, fwd_sum, rev_sub, sw_lo, sw_cl;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

  assign fwd_sum = add_sat(thr_q, cfg_i.ramp_steps[0 +: S]);
  assign rev_sub = sub_sat(thr_q, cfg_i.ramp_steps[S +: S]);
  assign sw_lo   = (sw_i < cfg_i.steer_right) ? cfg_i.steer_right : sw_i;
  assign sw_cl   = (sw_lo > cfg_i.steer_left) ? cfg_i.steer_left : sw_lo;

  always_comb begin
    case (spd_i)
      tgrs_pkg::SPEED_CREEP: begin
        fwd_tgt = cfg_i.fwd_targets[0 +: W];
        rev_tgt = cfg_i.rev_targets[0 +: W];
      end
      tgrs_pkg::SPEED_CRUISE: begin
        fwd_tgt = cfg_i.fwd_targets[W +: W];
        rev_tgt = cfg_i.rev_targets[W +: W];
      end
      default: begin
        fwd_tgt = cfg_i.fwd_targets[2*W +: W];
        rev_tgt = cfg_i.rev_targets[2*W +: W];
      end
    endcase
  end

  // ramp back to neutral; pre-reverse leaves everything as is
  always_comb begin
    stop_thr  = thr_q;
    stop_gear = gear_q;
    case (gear_q)
      tgrs_pkg::GEAR_IDLE: stop_thr = cfg_i.neutral_width;
      tgrs_pkg::GEAR_DRIVE: begin
        if (thr_q > cfg_i.neutral_width) begin
          stop_thr = sub_sat(thr_q, cfg_i.ramp_steps[2*S +: S]);
        end else begin
          stop_thr  = cfg_i.neutral_width;
          stop_gear = tgrs_pkg::GEAR_IDLE;
        end
      end
      tgrs_pkg::GEAR_REVERSE: begin
        if (thr_q < cfg_i.neutral_width) begin
          stop_thr = add_sat(thr_q, cfg_i.ramp_steps[3*S +: S]);
        end else begin
          stop_thr  = cfg_i.neutral_width;
          stop_gear = tgrs_pkg::GEAR_IDLE;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    thr_d  = thr_q;
    str_d  = str_q;
    gear_d = gear_q;
    hold_d = hold_q;
    wr_d   = 1'b1;
    case (op_i)
      tgrs_pkg::OP_FORWARD: begin
        if (gear_q == tgrs_pkg::GEAR_PREREV || gear_q == tgrs_pkg::GEAR_REVERSE) begin
          wr_d = 1'b0;
        end else if (spd_i == tgrs_pkg::SPEED_STOP) begin
          thr_d  = stop_thr;
          gear_d = stop_gear;
        end else begin
          if (thr_q < fwd_tgt) begin
            thr_d = (fwd_sum > fwd_tgt) ? fwd_tgt : fwd_sum;
          end else begin
            thr_d = fwd_tgt;
          end
          gear_d = tgrs_pkg::GEAR_DRIVE;
        end
      end
      tgrs_pkg::OP_REVERSE: begin
        case (gear_q)
          tgrs_pkg::GEAR_REVERSE: begin
            if (spd_i == tgrs_pkg::SPEED_STOP) begin
              thr_d  = stop_thr;
              gear_d = stop_gear;
            end else if (thr_q > rev_tgt) begin
              thr_d = rev_sub;   // no clamp at target on the way down
            end else begin
              thr_d = rev_tgt;
            end
          end
          tgrs_pkg::GEAR_DRIVE: begin
            thr_d  = stop_thr;
            gear_d = stop_gear;
          end
          tgrs_pkg::GEAR_IDLE: begin
            gear_d = tgrs_pkg::GEAR_PREREV;
            thr_d  = rev_sub;
          end
          default: begin
            if (thr_q > cfg_i.prerev_width) begin
              thr_d  = rev_sub;
              hold_d = '0;
            end else if (hold_q < cfg_i.prerev_hold) begin
              thr_d  = cfg_i.prerev_width;
              hold_d = hold_q + 1'b1;
            end else begin
              gear_d = tgrs_pkg::GEAR_REVERSE;
              thr_d  = cfg_i.neutral_width;
              hold_d = '0;
            end
          end
        endcase
      end
      tgrs_pkg::OP_STOP: begin
        thr_d  = stop_thr;
        gear_d = stop_gear;
      end
      default: begin   // steer
        str_d = sw_cl;
        wr_d  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= tgrs_pkg::RST_NEUTRAL_WIDTH;
      str_q   <= tgrs_pkg::RST_STEER_WIDTH;
      gear_q  <= tgrs_pkg::GEAR_IDLE;
      hold_q  <= '0;
      valid_q <= 1'b0;
    end else if (accept) begin
      thr_q   <= thr_d;
      str_q   <= str_d;
      gear_q  <= gear_d;
      hold_q  <= hold_d;
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.thr_width <= thr_d;
      item_q.str_width <= str_d;
      item_q.gear      <= gear_d;
      item_q.written   <= wr_d;
    end
  end

  // hold count only runs during the pre-reverse dip
  `TGRS_ASSERT_IMP(a_hold_only_prerev, clk_i, rst_ni, hold_q != '0,
                   gear_q == tgrs_pkg::GEAR_PREREV)
  // a command that does not write the throttle leaves throttle and gear alone
  `TGRS_ASSERT_NEXT(a_nowrite_keeps_thr, clk_i, rst_ni, accept && !wr_d,
                    thr_q == $past(thr_q) && gear_q == $past(gear_q))

endmodule

// File: rtl/core/tgrs_conv.sv
// Width-to-tick conversion pipeline: ticks = TICKS * width / USEC for both lanes.
// Depends on tgrs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tgrs_conv #(
  parameter int unsigned TIMER_TICKS     = tgrs_pkg::TIMER_TICKS_DEF,
  parameter int unsigned USEC_PER_PERIOD = tgrs_pkg::USEC_PER_PERIOD_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  tgrs_pkg::item_t             in_item_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [tgrs_pkg::TICK_W-1:0] thr_ticks_o,
  output logic [tgrs_pkg::TICK_W-1:0] str_ticks_o,
  output logic [1:0]                  gear_o,
  output logic                        written_o
);

  localparam int PW = tgrs_pkg::PROD_W;
  localparam int QW = PW + 1;
  localparam int EW = PW + QW;
  localparam int AW = tgrs_pkg::PAR_W;
  localparam longint unsigned RECIP_L = (64'd1 << PW) / USEC_PER_PERIOD;
  localparam logic [QW-1:0] RECIP = QW'(RECIP_L);
  localparam logic [AW-1:0] TICKS = AW'(TIMER_TICKS);
  localparam logic [AW-1:0] USEC  = AW'(USEC_PER_PERIOD);

  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  // lane 0 throttle, lane 1 steering
  logic [1:0][PW-1:0] p1_q, p2_q, p3_q;
  logic [1:0][EW-1:0] e2_q;
  logic [1:0][QW-1:0] qe3_q, c3_q, rem, q4;
  logic [1:0][tgrs_pkg::TICK_W-1:0] ticks_q;
  logic [1:0][1:0] gear_s;
  logic [3:0]      wr_s;
  logic [1:0]      gear4_q;
  logic [1:0]      gear_out_q;
  logic [1:0][tgrs_pkg::WID_W-1:0] w_in;

  assign rdy4 = !v4_q || out_ready_i;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  assign w_in[0] = in_item_i.thr_width;
  assign w_in[1] = in_item_i.str_width;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      rem[l] = {1'b0, p3_q[l]} - c3_q[l];
      q4[l]  = (rem[l] >= QW'(USEC)) ? qe3_q[l] + 1'b1 : qe3_q[l];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < 2; l++) begin
      if (rdy1 && in_valid_i) begin
        p1_q[l] <= {{tgrs_pkg::WID_W{1'b0}}, TICKS} * {{AW{1'b0}}, w_in[l]};
      end
      if (rdy2 && v1_q) begin
        p2_q[l] <= p1_q[l];
        e2_q[l] <= {{QW{1'b0}}, p1_q[l]} * {{PW{1'b0}}, RECIP};
      end
      if (rdy3 && v2_q) begin
        p3_q[l]  <= p2_q[l];
        qe3_q[l] <= e2_q[l][EW-1:PW];
        c3_q[l]  <= QW'(e2_q[l][EW-1:PW] * USEC);
      end
      if (rdy4 && v3_q) begin
        ticks_q[l] <= q4[l][tgrs_pkg::TICK_W-1:0];
      end
    end
    if (rdy1 && in_valid_i) begin
      gear_s[0] <= in_item_i.gear;
      wr_s[0]   <= in_item_i.written;
    end
    if (rdy2 && v1_q) begin
      gear_s[1] <= gear_s[0];
      wr_s[1]   <= wr_s[0];
    end
    if (rdy3 && v2_q) begin
      gear4_q <= gear_s[1];
      wr_s[2] <= wr_s[1];
    end
    if (rdy4 && v3_q) begin
      gear_out_q <= gear4_q;
      wr_s[3]    <= wr_s[2];
    end
  end

  assign out_valid_o = v4_q;
  assign thr_ticks_o = ticks_q[0];
  assign str_ticks_o = ticks_q[1];
  assign gear_o      = gear_out_q;
  assign written_o   = wr_s[3];

  // reciprocal estimate is never more than one short
  `TGRS_ASSERT_IMP(a_rem_bound, clk_i, rst_ni, v3_q,
                   rem[0] < (QW'(USEC) << 1) && rem[1] < (QW'(USEC) << 1))
  // a word in the last stage moves to the output when there is room
  `TGRS_ASSERT_NEXT(a_stage_advance, clk_i, rst_ni, v3_q && rdy4, v4_q)

endmodule

// File: rtl/core/throttle_gear_ramp_sequencer.sv
// Throttle/gear ramp sequencer top level: APB settings, command state update and
// tick conversion. Depends on tgrs_pkg, tgrs_cfg, tgrs_seq, tgrs_conv.
//
// Takes one command word per clock while s_axis_tready is high (forward,
// reverse, stop or steer with a speed grade or steering width) and returns one
// result word per command, in order: throttle and steering compare values in
// timer ticks, the gear after the command, and a flag telling whether the
// throttle output was written. The throttle/gear/hold state is updated at the
// edge the command is accepted, so the next command may follow in the very
// next cycle. The state-update output register loads at the accepting edge;
// four stages of width-to-tick conversion follow (multiply by TIMER_TICKS,
// multiply by a fixed reciprocal of USEC_PER_PERIOD, back-multiply for the
// remainder, one-step correction) before the result word is valid. Sustained
// rate is one word per cycle while the output is not stalled; each stage has
// its own ready, so a stalled output only backs up as far as it has to.
// Settings are written over APB at byte address 8*index and should change only
// while no command is in flight; they affect later commands only.

module throttle_gear_ramp_sequencer #(
  parameter int unsigned TIMER_TICKS     = tgrs_pkg::TIMER_TICKS_DEF,
  parameter int unsigned USEC_PER_PERIOD = tgrs_pkg::USEC_PER_PERIOD_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // command stream
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [15:0]                 s_axis_tdata,  // [1:0] speed, [13:2] steer_width
  input  logic [1:0]                  s_axis_tuser,  // [1:0] operation
  // result stream
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [39:0]                 m_axis_tdata,  // [15:0] throttle_ticks,
                                                     // [31:16] steering_ticks, [33:32] gear
  output logic [0:0]                  m_axis_tuser,  // [0] throttle_written
  // settings
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tgrs_pkg::ADDR_W-1:0] paddr,
  input  logic [tgrs_pkg::DATA_W-1:0] pwdata,
  output logic [tgrs_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  tgrs_pkg::cfg_t  cfg;
  tgrs_pkg::item_t item;
  logic            item_valid, item_ready;
  logic [tgrs_pkg::TICK_W-1:0] thr_ticks, str_ticks;
  logic [1:0]      gear;
  logic            written;

  tgrs_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready),
    .cfg_o     (cfg)
  );

  // state update happens on the accepting edge
  tgrs_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .op_i        (s_axis_tuser),
    .spd_i       (s_axis_tdata[1:0]),
    .sw_i        (s_axis_tdata[13:2]),
    .out_valid_o (item_valid),
    .out_ready_i (item_ready),
    .out_item_o  (item)
  );

  tgrs_conv #(
    .TIMER_TICKS     (TIMER_TICKS),
    .USEC_PER_PERIOD (USEC_PER_PERIOD)
  ) u_conv (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (item_valid),
    .in_ready_o  (item_ready),
    .in_item_i   (item),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .thr_ticks_o (thr_ticks),
    .str_ticks_o (str_ticks),
    .gear_o      (gear),
    .written_o   (written)
  );

  // pad to whole bytes
  assign m_axis_tdata = {6'd0, gear, str_ticks, thr_ticks};
  assign m_axis_tuser = written;

endmodule
